[hw/rtl/assert_macros.svh]
// Assertion macros shared by the stripper RTL modules.
// No dependencies; include by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is held.
`define POS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pos assertion failed");

// Clocked assertion, checked during reset too.
`define POS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("pos assertion failed");

`endif

[hw/rtl/pos_pkg.sv]
// Package for the PGS presentation object stripper: constants and the queue entry type.
// No dependencies.
`timescale 1ns / 1ps

package pos_pkg;

    localparam int unsigned MAX_BUFFER_BYTES = 65536;
    // Largest bytes_after value the walk honors; larger values saturate.
    localparam int unsigned AvailMax =
        (MAX_BUFFER_BYTES - 1 > 65535) ? 65535 : MAX_BUFFER_BYTES - 1;

    localparam logic [7:0] SegPresentation = 8'h16;
    localparam logic [7:0] CropFlagMask    = 8'h80;
    localparam logic [3:0] FixedBytes      = 4'd10;
    localparam logic [3:0] ObjectBytes     = 4'd8;
    localparam logic [3:0] CropByteLeft    = 4'd5;
    localparam logic [3:0] CropExtraBytes  = 4'd8;
    localparam logic [7:0] StrippedLength  = 8'(FixedBytes) + 8'd1;

    localparam int unsigned QueueDepth = 4;
    localparam int unsigned QPtrW      = $clog2(QueueDepth);
    localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

    // One queued request: one or two output bytes from a single input byte.
    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic       two;
        logic       valid0;
        logic       bend;
    } t_entry;

endpackage

[hw/rtl/pos_front.sv]
// Front end of the stripper: accepts input bytes, runs the segment walk, queues requests.
// Depends on pos_pkg.
`timescale 1ns / 1ps

module pos_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [7:0]      i_data_byte,
    input  logic [15:0]     i_bytes_after,
    input  logic            i_end_of_set,
    input  logic            i_queue_full,
    output logic            o_push,
    output pos_pkg::t_entry o_entry
);
    import pos_pkg::*;

    localparam logic [2:0] PhType  = 3'd0;
    localparam logic [2:0] PhLenHi = 3'd1;
    localparam logic [2:0] PhLenLo = 3'd2;
    localparam logic [2:0] PhSkip  = 3'd3;
    localparam logic [2:0] PhFixed = 3'd4;
    localparam logic [2:0] PhCount = 3'd5;
    localparam logic [2:0] PhObj   = 3'd6;
    localparam logic [2:0] PhPass  = 3'd7;

    logic [2:0]  r_phase, n_phase;
    logic        r_done, n_done;
    logic [7:0]  r_len_hi, n_len_hi;
    logic [15:0] r_skip, n_skip;
    logic [3:0]  r_fixed, n_fixed;
    logic [7:0]  r_objs, n_objs;
    logic [4:0]  r_obl, n_obl;
    logic        r_is_pres, n_is_pres;

    logic [15:0] avail;
    logic        bend;
    logic        accept;
    logic [1:0]  cnt;

    assign avail  = (i_bytes_after > 16'(AvailMax)) ? 16'(AvailMax) : i_bytes_after;
    assign bend   = (avail == 16'd0);
    assign o_ready = !i_queue_full;
    assign accept = i_valid && o_ready;
    assign o_push = accept && (cnt != 2'd0);

    always_comb begin
        logic [3:0]  v_r;
        logic        v_x;
        logic [7:0]  v_objs;
        logic [15:0] v_len;
        logic [15:0] v_skip;
        logic [3:0]  v_fixed;

        n_phase   = r_phase;
        n_done    = r_done;
        n_len_hi  = r_len_hi;
        n_skip    = r_skip;
        n_fixed   = r_fixed;
        n_objs    = r_objs;
        n_obl     = r_obl;
        n_is_pres = r_is_pres;
        cnt            = 2'd0;
        o_entry.byte0  = i_data_byte;
        o_entry.byte1  = i_data_byte;
        o_entry.two    = 1'b0;
        o_entry.valid0 = 1'b1;
        o_entry.bend   = bend;
        v_r     = r_obl[3:0];
        v_x     = r_obl[4];
        v_objs  = r_objs;
        v_len   = {r_len_hi, i_data_byte};
        v_skip  = r_skip - 16'd1;
        v_fixed = r_fixed + 4'd1;

        case (r_phase)
            PhType: begin
                cnt = 2'd1;
                if (r_done || avail < 16'd2) begin
                    n_phase = PhPass;
                end else begin
                    n_is_pres = (i_data_byte == SegPresentation);
                    n_phase   = PhLenHi;
                end
            end
            PhLenHi: begin
                // Hold the high length byte of a presentation segment.
                n_len_hi = i_data_byte;
                if (!r_is_pres || bend) begin
                    cnt = 2'd1;
                end
                n_phase = PhLenLo;
            end
            PhLenLo: begin
                if (r_is_pres && v_len <= avail) begin
                    cnt           = 2'd2;
                    o_entry.two   = 1'b1;
                    o_entry.byte0 = 8'h00;
                    o_entry.byte1 = StrippedLength;
                    n_done  = 1'b1;
                    n_fixed = 4'd0;
                    n_phase = PhFixed;
                end else begin
                    if (r_is_pres) begin
                        cnt           = 2'd2;
                        o_entry.two   = 1'b1;
                        o_entry.byte0 = r_len_hi;
                    end else begin
                        cnt = 2'd1;
                    end
                    n_skip  = v_len;
                    n_phase = (v_len == 16'd0) ? PhType : PhSkip;
                end
            end
            PhSkip: begin
                cnt    = 2'd1;
                n_skip = v_skip;
                if (v_skip == 16'd0) begin
                    n_phase = PhType;
                end
            end
            PhFixed: begin
                cnt     = 2'd1;
                n_fixed = v_fixed;
                if (v_fixed >= FixedBytes) begin
                    n_phase = PhCount;
                end
            end
            PhCount: begin
                // Zero the object count and, when it is nonzero, start dropping objects.
                cnt           = 2'd1;
                o_entry.byte0 = 8'h00;
                n_objs        = i_data_byte;
                n_obl         = {1'b0, ObjectBytes};
                n_phase       = (i_data_byte == 8'h00) ? PhPass : PhObj;
            end
            PhObj: begin
                if (!v_x && v_r == CropByteLeft) begin
                    v_x = 1'b1;
                    if ((i_data_byte & CropFlagMask) != 8'h00) begin
                        v_r = v_r + CropExtraBytes;
                    end
                end
                if (v_r != 4'd0) begin
                    v_r = v_r - 4'd1;
                end
                if (v_r == 4'd0) begin
                    v_objs = r_objs - 8'd1;
                    n_objs = v_objs;
                    if (v_objs == 8'd0) begin
                        n_phase = PhPass;
                        n_obl   = 5'd0;
                    end else begin
                        n_obl = {1'b0, ObjectBytes};
                    end
                end else begin
                    n_obl = {v_x, v_r};
                end
                if (bend) begin
                    cnt            = 2'd1;
                    o_entry.byte0  = 8'h00;
                    o_entry.valid0 = 1'b0;
                end
            end
            default: begin
                cnt = 2'd1;
            end
        endcase

        if (bend || i_end_of_set) begin
            n_phase   = PhType;
            n_len_hi  = 8'h00;
            n_skip    = 16'd0;
            n_fixed   = 4'd0;
            n_objs    = 8'h00;
            n_obl     = 5'd0;
            n_is_pres = 1'b0;
        end
        if (i_end_of_set) begin
            n_done = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PhType;
            r_done    <= 1'b0;
            r_len_hi  <= 8'h00;
            r_skip    <= 16'd0;
            r_fixed   <= 4'd0;
            r_objs    <= 8'h00;
            r_obl     <= 5'd0;
            r_is_pres <= 1'b0;
        end else if (accept) begin
            r_phase   <= n_phase;
            r_done    <= n_done;
            r_len_hi  <= n_len_hi;
            r_skip    <= n_skip;
            r_fixed   <= n_fixed;
            r_objs    <= n_objs;
            r_obl     <= n_obl;
            r_is_pres <= n_is_pres;
        end
    end

endmodule

[hw/rtl/pos_queue.sv]
// Request queue between the front and back ends of the stripper.
// Depends on pos_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pos_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  pos_pkg::t_entry i_entry,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_nonempty,
    output pos_pkg::t_entry o_head
);
    import pos_pkg::*;

    t_entry           r_mem [QueueDepth];
    logic [QPtrW-1:0] r_wr, r_rd;
    logic [QCntW-1:0] r_count;

    assign o_full     = (r_count == QCntW'(QueueDepth));
    assign o_nonempty = (r_count != '0);
    assign o_head     = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QPtrW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QPtrW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCntW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - QCntW'(1);
            end
        end
    end

    `POS_ASSERT(a_no_overflow, i_clk, i_rst_n, i_push |-> !o_full)
    `POS_ASSERT(a_no_underflow, i_clk, i_rst_n, i_pop |-> o_nonempty)
    `POS_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= QCntW'(QueueDepth))

endmodule

[hw/rtl/pos_back.sv]
// Back end of the stripper: plays out each queued request as one or two result bytes.
// Depends on pos_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pos_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_nonempty,
    input  pos_pkg::t_entry i_head,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_byte_valid,
    output logic            o_buffer_end,
    output logic            o_run_last
);
    import pos_pkg::*;

    logic r_second;
    logic last;
    logic take;

    assign o_valid      = i_nonempty;
    assign last         = r_second || !i_head.two;
    assign take         = o_valid && i_ready;
    assign o_pop        = take && last;
    assign o_out_byte   = r_second ? i_head.byte1 : i_head.byte0;
    assign o_byte_valid = r_second ? 1'b1 : i_head.valid0;
    assign o_run_last   = last;
    assign o_buffer_end = last && i_head.bend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_second <= 1'b0;
        end else if (take) begin
            r_second <= !last;
        end
    end

    `POS_ASSERT(a_second_needs_pair, i_clk, i_rst_n, r_second |-> (i_nonempty && i_head.two))
    `POS_ASSERT(a_second_holds, i_clk, i_rst_n, (r_second && !i_ready) |=> r_second)

endmodule

[hw/rtl/pgs_presentation_object_stripper_core.sv]
// A result byte is offered from the request queue, which registers each request the front pushes.
// Throughput: one input byte per cycle while the queue has room; a request of two result bytes
// always follows a held length byte that gives none, so one byte per cycle holds.
// The four-entry request queue sets how far the input runs ahead of a stalled output.
// Reset (synchronous, active low) restarts the segment walk and clears the rewrite-done mark.
// Depends on pos_pkg, pos_front, pos_queue, pos_back.
`timescale 1ns / 1ps

module pgs_presentation_object_stripper_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input request channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic [15:0] i_bytes_after,
    input  logic        i_end_of_set,
    // result request channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_byte_valid,
    output logic        o_buffer_end,
    output logic        o_run_last
);
    import pos_pkg::*;

    t_entry push_entry;
    t_entry head_entry;
    logic   push;
    logic   pop;
    logic   queue_full;
    logic   queue_nonempty;

    // Front: accept one byte per cycle while the queue has room, walk segment headers, strip the first
    // fitting presentation segment of each display set, and queue what to emit.
    pos_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_data_byte  (i_data_byte),
        .i_bytes_after(i_bytes_after),
        .i_end_of_set (i_end_of_set),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_entry      (push_entry)
    );

    // Queue: decouple the walk from output stalls.
    pos_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_entry   (push_entry),
        .i_pop     (pop),
        .o_full    (queue_full),
        .o_nonempty(queue_nonempty),
        .o_head    (head_entry)
    );

    // Back: drain each request as one or two result bytes, flagging the last
    // one and the buffer close.
    pos_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_nonempty  (queue_nonempty),
        .i_head      (head_entry),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_byte  (o_out_byte),
        .o_byte_valid(o_byte_valid),
        .o_buffer_end(o_buffer_end),
        .o_run_last  (o_run_last)
    );

endmodule

[dv/pgs_presentation_object_stripper_core_tb.sv]
// Self-checking testbench for pgs_presentation_object_stripper_core: directed and random PGS byte
// streams against a cycle-free model of the segment walk. Depends on pos_pkg and the core RTL.
`timescale 1ns / 1ps

module pgs_presentation_object_stripper_core_tb;

    import pos_pkg::*;

    localparam int unsigned ClkHalfNs   = 10;
    localparam int unsigned RunLimitNs  = 8_000_000;
    localparam int unsigned DrainLimit  = 4000;
    localparam int unsigned SettleCyc   = 4;
    localparam int unsigned MaxReported = 10;

    // Segment types other than the presentation segment.
    localparam logic [7:0] SegPalette = 8'h14;
    localparam logic [7:0] SegObject  = 8'h15;
    localparam logic [7:0] SegWindow  = 8'h17;
    localparam logic [7:0] SegEnd     = 8'h80;

    // Where the walk stands inside the current buffer.
    typedef enum logic [2:0] {
        WALK_TYPE,
        WALK_LEN_HI,
        WALK_LEN_LO,
        WALK_SKIP,
        WALK_FIXED,
        WALK_COUNT,
        WALK_OBJECTS,
        WALK_PASS
    } t_walk;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_PATTERN,
        STALL_RANDOM
    } t_stall;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       buffer_end;
        logic       run_last;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_data_byte;
    logic [15:0] i_bytes_after;
    logic        i_end_of_set;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_byte_valid;
    logic        o_buffer_end;
    logic        o_run_last;

    // Model of the segment walk.
    t_walk       walk;
    logic        strip_done;
    logic [7:0]  held_len_hi;
    logic [15:0] skip_cnt;
    logic [3:0]  fixed_cnt;
    logic [7:0]  objs_left;
    logic [3:0]  obj_bytes_left;
    logic        obj_crop_read;
    logic        is_pcs;

    // Rewritten stream still owed by the block, oldest first.
    t_result     rewritten_q[$];
    logic [7:0]  buffer_bytes[$];

    int unsigned mismatch_cnt = 0;
    int unsigned bytes_sent   = 0;
    int unsigned burst_left   = 0;
    bit          gaps_on      = 1'b0;
    t_stall      stall_mode   = STALL_NONE;
    logic [7:0]  stall_tick   = '0;

    pgs_presentation_object_stripper_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_data_byte   (i_data_byte),
        .i_bytes_after (i_bytes_after),
        .i_end_of_set  (i_end_of_set),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_byte    (o_out_byte),
        .o_byte_valid  (o_byte_valid),
        .o_buffer_end  (o_buffer_end),
        .o_run_last    (o_run_last)
    );

    always #(ClkHalfNs) i_clk = ~i_clk;

    // Hard stop in case the block hangs on either handshake.
    initial begin
        #(RunLimitNs);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------
    // Model
    // ------------------------------------------------------------------

    // Drop back to a header type byte, as at every buffer or set end.
    function automatic void rewind_walk();
        walk           = WALK_TYPE;
        held_len_hi    = '0;
        skip_cnt       = '0;
        fixed_cnt      = '0;
        objs_left      = '0;
        obj_bytes_left = '0;
        obj_crop_read  = 1'b0;
        is_pcs         = 1'b0;
    endfunction

    function automatic t_result pass_byte(input logic [7:0] b);
        pass_byte = '{out_byte: b, byte_valid: 1'b1, buffer_end: 1'b0, run_last: 1'b0};
    endfunction

    // Advance the walk by one accepted request and queue the bytes it yields.
    function automatic void predict_strip(input logic [7:0] b, input logic [15:0] after,
                                          input logic eos);
        t_result     res[2];
        int          n;
        int unsigned avail;
        logic        bend;
        logic [15:0] seg_len;
        logic [3:0]  left;
        logic        crop;
        n     = 0;
        avail = (after > AvailMax) ? AvailMax : after;
        bend  = (avail == 0);
        case (walk)
            WALK_TYPE: begin
                res[n] = pass_byte(b);
                n = n + 1;
                // Once stripped, or too short for a header: pass the rest of the buffer.
                if (strip_done || avail < 2) begin
                    walk = WALK_PASS;
                end else begin
                    is_pcs = (b == SegPresentation);
                    walk   = WALK_LEN_HI;
                end
            end
            WALK_LEN_HI: begin
                // Hold the high length byte of a presentation segment unless the buffer ends.
                held_len_hi = b;
                if (!is_pcs || bend) begin
                    res[n] = pass_byte(b);
                    n = n + 1;
                end
                walk = WALK_LEN_LO;
            end
            WALK_LEN_LO: begin
                seg_len = {held_len_hi, b};
                if (is_pcs && seg_len <= avail) begin
                    res[0]     = pass_byte(8'h00);
                    res[1]     = pass_byte(StrippedLength);
                    n          = 2;
                    strip_done = 1'b1;
                    fixed_cnt  = '0;
                    walk       = WALK_FIXED;
                end else begin
                    if (is_pcs) begin
                        res[n] = pass_byte(held_len_hi);
                        n = n + 1;
                    end
                    res[n] = pass_byte(b);
                    n = n + 1;
                    skip_cnt = seg_len;
                    walk     = (seg_len == 0) ? WALK_TYPE : WALK_SKIP;
                end
            end
            WALK_SKIP: begin
                res[n] = pass_byte(b);
                n = n + 1;
                skip_cnt = skip_cnt - 16'd1;
                if (skip_cnt == 0) walk = WALK_TYPE;
            end
            WALK_FIXED: begin
                res[n] = pass_byte(b);
                n = n + 1;
                fixed_cnt = fixed_cnt + 4'd1;
                if (fixed_cnt >= FixedBytes) walk = WALK_COUNT;
            end
            WALK_COUNT: begin
                res[n] = pass_byte(8'h00);
                n = n + 1;
                objs_left      = b;
                obj_bytes_left = ObjectBytes;
                obj_crop_read  = 1'b0;
                walk           = (b == 0) ? WALK_PASS : WALK_OBJECTS;
            end
            WALK_OBJECTS: begin
                // Drop object bytes; the crop flag byte may stretch the object by eight.
                left = obj_bytes_left;
                crop = obj_crop_read;
                if (!crop && left == CropByteLeft) begin
                    crop = 1'b1;
                    if ((b & CropFlagMask) != 0) left = left + CropExtraBytes;
                end
                if (left != 0) left = left - 4'd1;
                if (left == 0) begin
                    objs_left     = objs_left - 8'd1;
                    obj_crop_read = 1'b0;
                    if (objs_left == 0) begin
                        walk           = WALK_PASS;
                        obj_bytes_left = '0;
                    end else begin
                        obj_bytes_left = ObjectBytes;
                    end
                end else begin
                    obj_bytes_left = left;
                    obj_crop_read  = crop;
                end
                // A drop clamped at the buffer end still has to close the buffer.
                if (bend) begin
                    res[n] = '{out_byte: 8'h00, byte_valid: 1'b0, buffer_end: 1'b0,
                               run_last: 1'b0};
                    n = n + 1;
                end
            end
            default: begin
                res[n] = pass_byte(b);
                n = n + 1;
            end
        endcase
        if (n > 0) begin
            res[n-1].run_last   = 1'b1;
            res[n-1].buffer_end = bend;
        end
        for (int k = 0; k < n; k++) rewritten_q.push_back(res[k]);
        if (bend || eos) rewind_walk();
        if (eos) strip_done = 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    task automatic note_error(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= MaxReported) $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // Receiver readiness: always ready, a fixed stall pattern, or coin flips.
    always @(posedge i_clk) begin
        stall_tick <= stall_tick + 8'd1;
        case (stall_mode)
            STALL_NONE:    i_ready <= 1'b1;
            STALL_PATTERN: i_ready <= (stall_tick[2:0] != 3'd5) &&
                                      !(stall_tick[5:4] == 2'b11 && stall_tick[1]);
            default:       i_ready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // Compare every accepted result with the oldest expected byte, field by field.
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (rewritten_q.size() == 0) begin
                note_error($sformatf("result with no request pending: byte %02h valid %0b",
                                     o_out_byte, o_byte_valid));
            end else begin
                want = rewritten_q.pop_front();
                if (o_out_byte !== want.out_byte)
                    note_error($sformatf("out_byte: expected %02h, got %02h",
                                         want.out_byte, o_out_byte));
                if (o_byte_valid !== want.byte_valid)
                    note_error($sformatf("byte_valid: expected %0b, got %0b",
                                         want.byte_valid, o_byte_valid));
                if (o_buffer_end !== want.buffer_end)
                    note_error($sformatf("buffer_end: expected %0b, got %0b",
                                         want.buffer_end, o_buffer_end));
                if (o_run_last !== want.run_last)
                    note_error($sformatf("run_last: expected %0b, got %0b",
                                         want.run_last, o_run_last));
            end
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Offer one request and hold it until accepted; insert a gap between bursts.
    task automatic send_req(input logic [7:0] b, input logic [15:0] after, input logic eos);
        if (gaps_on) begin
            if (burst_left == 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
        end
        i_valid       <= 1'b1;
        i_data_byte   <= b;
        i_bytes_after <= after;
        i_end_of_set  <= eos;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_strip(b, after, eos);
        bytes_sent++;
    endtask

    // Hold the sender until every expected byte is back, then let the pipe settle.
    task automatic drain_results();
        int unsigned guard;
        guard = 0;
        i_valid <= 1'b0;
        while (rewritten_q.size() != 0 && guard < DrainLimit) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (SettleCyc) @(posedge i_clk);
    endtask

    // Append a non-presentation segment; now and then claim a random length instead of the true one.
    task automatic add_segment(input int unsigned len);
        logic [7:0]  seg_type;
        logic [15:0] claim;
        case ($urandom_range(0, 4))
            0:       seg_type = SegPalette;
            1:       seg_type = SegObject;
            2:       seg_type = SegWindow;
            3:       seg_type = SegEnd;
            default: seg_type = 8'($urandom);
        endcase
        claim = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535)) : 16'(len);
        buffer_bytes.push_back(seg_type);
        buffer_bytes.push_back(claim[15:8]);
        buffer_bytes.push_back(claim[7:0]);
        repeat (len) buffer_bytes.push_back(8'($urandom));
    endtask

    // Append a presentation segment with up to three objects, some cropped.
    task automatic add_presentation();
        logic [7:0]  payload[$];
        int unsigned n_obj;
        logic [15:0] seg_len;
        bit          crop;
        n_obj = $urandom_range(0, 3);
        repeat (FixedBytes) payload.push_back(8'($urandom));
        // Mostly an honest count; a wild one drives the drop into later bytes.
        payload.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'(n_obj));
        repeat (n_obj) begin
            crop = 1'($urandom_range(0, 1));
            repeat (3) payload.push_back(8'($urandom));
            payload.push_back(crop ? (8'($urandom) | CropFlagMask)
                                   : (8'($urandom) & ~CropFlagMask));
            repeat (crop ? 12 : 4) payload.push_back(8'($urandom));
        end
        seg_len = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 40))
                                              : 16'(payload.size());
        buffer_bytes.push_back(SegPresentation);
        buffer_bytes.push_back(seg_len[15:8]);
        buffer_bytes.push_back(seg_len[7:0]);
        foreach (payload[i]) buffer_bytes.push_back(payload[i]);
    endtask

    task automatic build_buffer();
        int unsigned n_seg;
        buffer_bytes.delete();
        n_seg = $urandom_range(1, 4);
        repeat (n_seg) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: add_presentation();
                4:          add_segment(0);
                default:    add_segment($urandom_range(1, 12));
            endcase
        end
        // Leave a torn header at the tail now and then.
        if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 2)) buffer_bytes.push_back(8'($urandom));
    endtask

    // Send the built buffer, sometimes cut short so it ends early inside a segment.
    task automatic send_buffer(input bit closes_set);
        int unsigned size;
        int unsigned cut;
        size = buffer_bytes.size();
        cut  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, size) : size;
        for (int unsigned i = 0; i < cut; i++) begin
            if (i == cut - 1)
                send_req(buffer_bytes[i], 16'd0, closes_set);
            else
                send_req(buffer_bytes[i], 16'(size - 1 - i), ($urandom_range(0, 299) == 0));
        end
    endtask

    // Unstructured bytes with arbitrary buffer positions and set ends.
    task automatic send_noise(input int unsigned count);
        repeat (count)
            send_req(8'($urandom),
                     ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(0, 65535)),
                     ($urandom_range(0, 7) == 0));
    endtask

    task automatic send_display_set();
        int unsigned n_buf;
        n_buf = $urandom_range(1, 3);
        for (int unsigned k = 0; k < n_buf; k++) begin
            if ($urandom_range(0, 9) == 0) begin
                send_noise($urandom_range(1, 12));
            end else begin
                build_buffer();
                send_buffer(k == n_buf - 1);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Headers with fewer than three bytes left pass through untouched.
    task automatic test_short_headers();
        send_req(8'hFF, 16'd0, 1'b1);
        send_req(8'h00, 16'd1, 1'b0);
        send_req(8'h7F, 16'd0, 1'b0);
    endtask

    // The held high length byte comes back out when the buffer ends on it.
    task automatic test_held_length_at_buffer_end();
        send_req(SegPresentation, 16'd2, 1'b0);
        send_req(8'hFF, 16'd0, 1'b1);
    endtask

    // A presentation segment longer than its buffer passes through to the end.
    task automatic test_unfit_presentation();
        send_req(SegPresentation, 16'd4, 1'b0);
        send_req(8'h01, 16'd3, 1'b0);
        send_req(8'h00, 16'd2, 1'b0);
        send_req(8'hAB, 16'd1, 1'b0);
        send_req(8'hCD, 16'd0, 1'b1);
    endtask

    // Buffer ends inside the fixed bytes; the set still counts as stripped, so a
    // second presentation segment in the same set passes through.
    task automatic test_short_presentation();
        send_req(SegPresentation, 16'd20, 1'b0);
        send_req(8'h00, 16'd19, 1'b0);
        send_req(8'h05, 16'd18, 1'b0);
        send_req(8'h3C, 16'd0, 1'b0);
        send_req(SegPresentation, 16'd3, 1'b0);
        send_req(8'h00, 16'd0, 1'b1);
    endtask

    // Full strip with a cropped object whose drop is clamped at the buffer end.
    task automatic test_strip_with_crop_clamp();
        send_req(SegPresentation, 16'hFFFF, 1'b0);
        send_req(8'h00, 16'hFFFE, 1'b0);
        send_req(StrippedLength, 16'hFFFD, 1'b0);
        for (int i = 0; i < FixedBytes; i++) send_req(8'($urandom), 16'(100 - i), 1'b0);
        send_req(8'd2, 16'd50, 1'b0);
        send_req(8'h00, 16'd40, 1'b0);
        send_req(8'hFF, 16'd39, 1'b0);
        send_req(8'h12, 16'd38, 1'b0);
        send_req(CropFlagMask, 16'd37, 1'b0);
        send_req(8'h55, 16'd0, 1'b1);
    endtask

    task automatic test_random_sets(input int unsigned count);
        int unsigned target;
        target = bytes_sent + count;
        while (bytes_sent < target) send_display_set();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_data_byte   <= '0;
        i_bytes_after <= '0;
        i_end_of_set  <= 1'b0;
        rewind_walk();
        strip_done = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_short_headers();
        test_held_length_at_buffer_end();
        test_unfit_presentation();
        test_short_presentation();
        test_strip_with_crop_clamp();
        drain_results();

        // Random display sets under each idling mix, fully drained in between.
        gaps_on    = 1'b0;
        stall_mode = STALL_NONE;
        test_random_sets(400);
        drain_results();

        gaps_on = 1'b1;
        test_random_sets(400);
        drain_results();

        gaps_on    = 1'b0;
        stall_mode = STALL_PATTERN;
        test_random_sets(400);
        drain_results();

        gaps_on    = 1'b1;
        stall_mode = STALL_RANDOM;
        test_random_sets(400);
        drain_results();

        if (rewritten_q.size() != 0)
            note_error($sformatf("%0d expected bytes never arrived", rewritten_q.size()));
        if (mismatch_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
